// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  // queue size and derived widths
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = VALUE_W + PRIO_W;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // circular pointer step forward
  function automatic addr_t ptr_inc(addr_t p);
    addr_t r;
    if (p == ADDR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // circular pointer step back
  function automatic addr_t ptr_dec(addr_t p);
    addr_t r;
    if (p == '0) r = ADDR_W'(QUEUE_DEPTH - 1);
    else r = p - 1'b1;
    return r;
  endfunction

endpackage

// ===== hdl/spq_ram.sv =====
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Bounded priority queue, lowest priority number at the front, equal
// priorities leave in arrival order.
// Input channel s_axis: tuser is the operation (insert or delete), tdata
// carries value and priority. Output channel m_axis: one result item per
// input item, tuser is the status (ok, underflow, overflow), tdata carries
// the removed value and priority (zero unless a delete succeeded) and the
// occupancy after the operation.
// Entries live in a single-port-read RAM used as a ring: a delete reads the
// head entry and advances the head pointer. An insert walks back from the
// tail, one RAM read and one compare per entry, moving each entry with a
// larger priority number up by one slot before writing the new one.
// An underflow or overflow is answered from the start state. A delete
// goes on through a RAM read and a compare, then registers the removed
// entry. An insert does a read and a compare for each entry it looks at,
// stopping at one it may follow or once it has moved every entry, and then
// writes the new entry in a place step. tready rises in the same cycle as
// result valid; one item is worked on at a time.
// A finished result sits in the output register until taken; a new item may
// be accepted meanwhile, but its result waits until the register is free.
// Reset empties the queue; RAM contents need no clearing.
module stable_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // item_value, item_priority
  input  logic                              s_axis_tuser,  // operation
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // removed_value, removed_priority, occupancy, 3 zero bits
  output logic [spq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [spq_pkg::STAT_W-1:0]        m_axis_tuser   // status
);

  import spq_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               place_q, place_d;
  logic               op_q, op_d;
  entry_t             item_q, item_d;
  addr_t              head_q, head_d;
  addr_t              tail_q, tail_d;
  addr_t              ptr_q, ptr_d;
  addr_t              wr_ptr_q, wr_ptr_d;
  count_t             count_q, count_d;
  count_t             left_q, left_d;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  entry_t             out_entry_q, out_entry_d;
  logic [OCC_W-1:0]   out_occ_q, out_occ_d;

  logic               out_free;
  logic               ram_we, ram_re;
  addr_t              ram_waddr;
  entry_t             ram_wdata, ram_rdata;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ptr_q),
    .rd_data_o (ram_rdata)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !place_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_entry_q};

  // sequencer
  always_comb begin
    state_d     = state_q;
    place_d     = place_q;
    op_d        = op_q;
    item_d      = item_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ptr_d       = ptr_q;
    wr_ptr_d    = wr_ptr_q;
    count_d     = count_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_entry_d = out_entry_q;
    out_occ_d   = out_occ_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = wr_ptr_q;
    ram_wdata   = item_q;

    case (state_q)
      S_IDLE: begin
        if (place_q) begin
          // new entry goes into the slot left free by the walk
          if (out_free) begin
            ram_we      = 1'b1;
            place_d     = 1'b0;
            tail_d      = ptr_inc(tail_q);
            count_d     = count_q + 1'b1;
            out_valid_d = 1'b1;
            out_stat_d  = ST_OK;
            out_entry_d = '0;
            out_occ_d   = OCC_W'(count_q + 1'b1);
          end
        end else if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          item_d  = entry_t'(s_axis_tdata[ENTRY_W-1:0]);
          state_d = S_START;
        end
      end

      S_START: begin
        if (op_q == OP_DELETE) begin
          if (count_q == '0) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_stat_d  = ST_UNDERFLOW;
              out_entry_d = '0;
              out_occ_d   = OCC_W'(count_q);
              state_d     = S_IDLE;
            end
          end else begin
            ptr_d   = head_q;
            state_d = S_READ;
          end
        end else begin
          if (count_q == COUNT_W'(QUEUE_DEPTH)) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_stat_d  = ST_OVERFLOW;
              out_entry_d = '0;
              out_occ_d   = OCC_W'(count_q);
              state_d     = S_IDLE;
            end
          end else begin
            wr_ptr_d = tail_q;
            ptr_d    = ptr_dec(tail_q);
            left_d   = count_q;
            if (count_q == '0) begin
              place_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_READ;
            end
          end
        end
      end

      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_CMP;
      end

      S_CMP: begin
        if (op_q == OP_DELETE) begin
          // front entry leaves
          if (out_free) begin
            head_d      = ptr_inc(head_q);
            count_d     = count_q - 1'b1;
            out_valid_d = 1'b1;
            out_stat_d  = ST_OK;
            out_entry_d = ram_rdata;
            out_occ_d   = OCC_W'(count_q - 1'b1);
            state_d     = S_IDLE;
          end
        end else if (ram_rdata.prio > item_q.prio) begin
          // stored entry ranks behind the new one: move it up a slot
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          wr_ptr_d  = ptr_q;
          ptr_d     = ptr_dec(ptr_q);
          left_d    = left_q - 1'b1;
          if (left_q == COUNT_W'(1)) begin
            place_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end else begin
          // found the spot behind an equal or smaller priority
          place_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      place_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      place_q     <= place_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    item_q      <= item_d;
    ptr_q       <= ptr_d;
    wr_ptr_q    <= wr_ptr_d;
    left_q      <= left_d;
    out_stat_q  <= out_stat_d;
    out_entry_q <= out_entry_d;
    out_occ_q   <= out_occ_d;
  end

endmodule

// ===== hdl/spq_checker.sv =====
module spq_props (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [spq_pkg::STAT_W-1:0]     m_axis_tuser
);

  import spq_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second item while busy");

  // underflow only on an empty queue, nothing removed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_UNDERFLOW |->
      m_axis_tdata == '0)
    else $error("underflow with nonzero payload");

  // overflow only on a full queue, nothing removed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OVERFLOW |->
      m_axis_tdata[ENTRY_W-1:0] == '0 &&
      m_axis_tdata[ENTRY_W+OCC_W-1:ENTRY_W] == OCC_W'(QUEUE_DEPTH))
    else $error("overflow on a queue that is not full");

endmodule

bind stable_priority_queue spq_props u_spq_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
